### rtl/core/mfa_pkg.sv
// shared types, codes and constants of the mixed fraction accumulator
package mfa_pkg;

    localparam int DATA_W          = 32;
    localparam int KIND_W          = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    // operation codes as they arrive on the kind field
    localparam logic [KIND_W-1:0] KIND_SET  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INC  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEC  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NORM = 3'd5;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef enum logic [2:0] {
        OP_SET,
        OP_ADD,
        OP_MUL,
        OP_INC,
        OP_DEC,
        OP_NORM
    } op_t;

    typedef struct packed {
        op_t   op;
        word_t whole;
        word_t numer;
        word_t denom;
    } item_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quotient;
        word_t remainder;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_COMBINE,
        ST_CROSS,
        ST_SUM,
        ST_DEN,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_DIVN_START,
        ST_DIVN_WAIT,
        ST_DIVD_START,
        ST_DIVD_WAIT,
        ST_FOLD,
        ST_FOLD_WAIT,
        ST_EMIT
    } bk_state_t;

endpackage

### rtl/core/mfa_front.sv
// front end: accepts items, decodes the kind and drops unused codes
module mfa_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mfa_pkg::KIND_W-1:0]          kind,
    input  logic signed [mfa_pkg::DATA_W-1:0]   operand_whole,
    input  logic signed [mfa_pkg::DATA_W-1:0]   operand_numerator,
    input  logic signed [mfa_pkg::DATA_W-1:0]   operand_denominator,
    output logic                                push,
    output mfa_pkg::item_t                      push_item,
    input  logic                                q_full
);
    import mfa_pkg::*;

    logic  hold_valid_reg, hold_valid_next;
    logic  hold_keep_reg, hold_keep_next;
    item_t hold_item_reg, hold_item_next;
    logic  retire;
    logic  accept;
    op_t   dec_op;
    logic  dec_keep;

    // kind decode
    always_comb
    begin
        dec_keep = 1'b1;
        dec_op   = OP_SET;
        case (kind)
            KIND_SET:  dec_op = OP_SET;
            KIND_ADD:  dec_op = OP_ADD;
            KIND_MUL:  dec_op = OP_MUL;
            KIND_INC:  dec_op = OP_INC;
            KIND_DEC:  dec_op = OP_DEC;
            KIND_NORM: dec_op = OP_NORM;
            default:   dec_keep = 1'b0;
        endcase
    end

    assign push      = hold_valid_reg && hold_keep_reg && !q_full;
    assign retire    = hold_valid_reg && (!hold_keep_reg || !q_full);
    assign in_ready  = !hold_valid_reg || retire;
    assign accept    = in_valid && in_ready;
    assign push_item = hold_item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg && !retire;
        hold_keep_next  = hold_keep_reg;
        hold_item_next  = hold_item_reg;
        if (accept)
        begin
            hold_valid_next      = 1'b1;
            hold_keep_next       = dec_keep;
            hold_item_next.op    = dec_op;
            hold_item_next.whole = operand_whole;
            hold_item_next.numer = operand_numerator;
            hold_item_next.denom = operand_denominator;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_keep_reg <= hold_keep_next;
        hold_item_reg <= hold_item_next;
    end

endmodule

### rtl/core/mfa_queue.sv
// small item queue between front and back
module mfa_queue #(
    parameter int DEPTH = mfa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mfa_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output mfa_pkg::item_t head_item
);
    import mfa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(DEPTH)))
        else $error("queue written while full");

endmodule

### rtl/core/mfa_divider.sv
// signed truncating divider, one quotient bit per cycle
module mfa_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  mfa_pkg::div_req_t req,
    output mfa_pkg::div_rsp_t rsp
);
    import mfa_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DATA_W-1:0]  quo_reg, quo_next;
    logic [DATA_W-1:0]  rem_reg, rem_next;
    logic [DATA_W-1:0]  dvs_reg, dvs_next;
    logic               neg_q_reg, neg_q_next;
    logic               neg_r_reg, neg_r_next;
    word_t              res_q_reg, res_q_next;
    word_t              res_r_reg, res_r_next;

    logic [DATA_W:0]    shifted;
    logic [DATA_W:0]    diff;
    logic               fits;
    logic [DATA_W-1:0]  rem_step;
    logic [DATA_W-1:0]  quo_step;
    logic [DATA_W-1:0]  mag_a;
    logic [DATA_W-1:0]  mag_b;

    assign mag_a = req.dividend[DATA_W-1] ? -req.dividend : req.dividend;
    assign mag_b = req.divisor[DATA_W-1]  ? -req.divisor  : req.divisor;

    // restoring step
    assign shifted  = {rem_reg, quo_reg[DATA_W-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign fits     = !diff[DATA_W];
    assign rem_step = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    assign quo_step = {quo_reg[DATA_W-2:0], fits};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        res_q_next = res_q_reg;
        res_r_next = res_r_reg;
        if (req.start)
        begin
            if (req.divisor == '0)
            begin
                // divide by zero: quotient zero, remainder is the dividend
                done_next  = 1'b1;
                res_q_next = '0;
                res_r_next = req.dividend;
            end
            else
            begin
                busy_next  = 1'b1;
                cnt_next   = '0;
                quo_next   = mag_a;
                rem_next   = '0;
                dvs_next   = mag_b;
                neg_q_next = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
                neg_r_next = req.dividend[DATA_W-1];
            end
        end
        else if (busy_reg)
        begin
            quo_next = quo_step;
            rem_next = rem_step;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                res_q_next = neg_q_reg ? -quo_step : quo_step;
                res_r_next = neg_r_reg ? -rem_step : rem_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        res_q_reg <= res_q_next;
        res_r_reg <= res_r_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = res_q_reg;
    assign rsp.remainder = res_r_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

endmodule

### rtl/core/mfa_back.sv
// back end: accumulator state, shared multiplier and normalize sequencer
module mfa_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               head_valid,
    input  mfa_pkg::item_t                     head_item,
    output logic                               pop,
    output mfa_pkg::div_req_t                  div_req,
    input  mfa_pkg::div_rsp_t                  div_rsp,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mfa_pkg::DATA_W-1:0]  result_whole,
    output logic signed [mfa_pkg::DATA_W-1:0]  result_numerator,
    output logic signed [mfa_pkg::DATA_W-1:0]  result_denominator,
    output logic                               zero_denominator
);
    import mfa_pkg::*;

    bk_state_t state_reg, state_next;

    word_t whole_reg, whole_next;
    word_t num_reg, num_next;
    word_t den_reg, den_next;

    op_t   cur_op_reg, cur_op_next;
    word_t cur_w_reg, cur_w_next;
    word_t cur_n_reg, cur_n_next;
    word_t cur_d_reg, cur_d_next;

    word_t p_reg, p_next;
    word_t a1_reg, a1_next;
    word_t a2_reg, a2_next;
    word_t gm_reg, gm_next;
    word_t gn_reg, gn_next;
    logic  zden_reg, zden_next;

    logic  out_valid_reg, out_valid_next;
    word_t out_whole_reg, out_whole_next;
    word_t out_num_reg, out_num_next;
    word_t out_den_reg, out_den_next;
    logic  out_zden_reg, out_zden_next;

    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [DATA_W-1:0] mul_p;

    // one shared multiplier, low half only
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_A:
            begin
                mul_a = whole_reg;
                mul_b = den_reg;
            end
            ST_MUL_B:
            begin
                mul_a = cur_w_reg;
                mul_b = cur_d_reg;
            end
            ST_COMBINE:
            begin
                mul_a = a1_reg;
                mul_b = (cur_op_reg == OP_MUL) ? a2_reg : cur_d_reg;
            end
            ST_CROSS:
            begin
                mul_a = a2_reg;
                mul_b = den_reg;
            end
            ST_DEN:
            begin
                mul_a = den_reg;
                mul_b = cur_d_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next     = state_reg;
        whole_next     = whole_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        cur_op_next    = cur_op_reg;
        cur_w_next     = cur_w_reg;
        cur_n_next     = cur_n_reg;
        cur_d_next     = cur_d_reg;
        p_next         = p_reg;
        a1_next        = a1_reg;
        a2_next        = a2_reg;
        gm_next        = gm_reg;
        gn_next        = gn_reg;
        zden_next      = zden_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_whole_next = out_whole_reg;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        out_zden_next  = out_zden_reg;
        pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = gm_reg;
        div_req.divisor  = gn_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop         = 1'b1;
                    cur_op_next = head_item.op;
                    cur_w_next  = head_item.whole;
                    cur_n_next  = head_item.numer;
                    cur_d_next  = head_item.denom;
                    case (head_item.op)
                        OP_SET:
                        begin
                            whole_next = head_item.whole;
                            num_next   = head_item.numer;
                            den_next   = head_item.denom;
                        end
                        OP_INC:  whole_next = whole_reg + word_t'(1);
                        OP_DEC:  whole_next = whole_reg - word_t'(1);
                        OP_ADD,
                        OP_MUL:  state_next = ST_MUL_A;
                        OP_NORM:
                        begin
                            if (den_reg == '0)
                            begin
                                zden_next  = 1'b1;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                zden_next  = 1'b0;
                                gm_next    = num_reg;
                                gn_next    = den_reg;
                                state_next = ST_GCD_START;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            // improper numerators of accumulator and operand
            ST_MUL_A:
            begin
                p_next     = mul_p;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                a1_next    = p_reg + num_reg;
                p_next     = mul_p;
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                a2_next    = p_reg + cur_n_reg;
                state_next = ST_COMBINE;
            end
            ST_COMBINE:
            begin
                if (cur_op_reg == OP_MUL)
                begin
                    num_next   = mul_p;
                    state_next = ST_DEN;
                end
                else if (den_reg == cur_d_reg)
                begin
                    num_next   = a1_reg + a2_reg;
                    whole_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    p_next     = mul_p;
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS:
            begin
                a1_next    = p_reg;
                p_next     = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                num_next   = a1_reg + p_reg;
                state_next = ST_DEN;
            end
            ST_DEN:
            begin
                den_next   = mul_p;
                whole_next = '0;
                state_next = ST_IDLE;
            end

            // euclid loop, gm ends up as the gcd
            ST_GCD_START:
            begin
                if (gn_reg == '0)
                begin
                    state_next = ST_DIVN_START;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    gm_next    = gn_reg;
                    gn_next    = div_rsp.remainder;
                    state_next = ST_GCD_START;
                end
            end
            ST_DIVN_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = num_reg;
                div_req.divisor  = gm_reg;
                state_next       = ST_DIVN_WAIT;
            end
            ST_DIVN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    num_next   = div_rsp.quotient;
                    state_next = ST_DIVD_START;
                end
            end
            ST_DIVD_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = den_reg;
                div_req.divisor  = gm_reg;
                state_next       = ST_DIVD_WAIT;
            end
            ST_DIVD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    den_next   = div_rsp.quotient;
                    state_next = ST_FOLD;
                end
            end

            // fold the improper part into the whole part
            ST_FOLD:
            begin
                if (num_reg == den_reg)
                begin
                    whole_next = whole_reg + word_t'(1);
                    num_next   = '0;
                    den_next   = word_t'(1);
                    state_next = ST_EMIT;
                end
                else if (num_reg > den_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = num_reg;
                    div_req.divisor  = den_reg;
                    state_next       = ST_FOLD_WAIT;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_FOLD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    whole_next = whole_reg + div_rsp.quotient;
                    num_next   = div_rsp.remainder;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_zden_next  = zden_reg;
                    out_whole_next = zden_reg ? '0 : whole_reg;
                    out_num_next   = zden_reg ? '0 : num_reg;
                    out_den_next   = zden_reg ? '0 : den_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            whole_reg     <= '0;
            num_reg       <= '0;
            den_reg       <= word_t'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            whole_reg     <= whole_next;
            num_reg       <= num_next;
            den_reg       <= den_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_op_reg    <= cur_op_next;
        cur_w_reg     <= cur_w_next;
        cur_n_reg     <= cur_n_next;
        cur_d_reg     <= cur_d_next;
        p_reg         <= p_next;
        a1_reg        <= a1_next;
        a2_reg        <= a2_next;
        gm_reg        <= gm_next;
        gn_reg        <= gn_next;
        zden_reg      <= zden_next;
        out_whole_reg <= out_whole_next;
        out_num_reg   <= out_num_next;
        out_den_reg   <= out_den_next;
        out_zden_reg  <= out_zden_next;
    end

    assign out_valid          = out_valid_reg;
    assign result_whole       = out_whole_reg;
    assign result_numerator   = out_num_reg;
    assign result_denominator = out_den_reg;
    assign zero_denominator   = out_zden_reg;

    a_fold_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |-> (den_reg != '0))
        else $error("reduced denominator is zero at fold");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result raised outside the emit step");

endmodule

### rtl/core/mixed_fraction_accumulator_unit.sv
// top level of the mixed fraction accumulator
// flow: front register, then queue, then the back, where set/inc/dec apply on pop;
//   add and multiply run MUL_A, MUL_B, MUL_C, COMBINE on the shared 32x32 multiplier,
//   then multiply runs DEN and add ends or, on unequal denominators, runs CROSS, SUM, DEN;
//   normalize: euclid steps, two reductions and at most one fold division, then emit
// throughput: the front takes one item per cycle until the queue fills; the back
//   finishes one item at a time, so sustained rate follows the mix of kinds
// reset: rst_n asynchronous active low; accumulator goes to 0 + 0/1, queue and output empty
//
// structure
//   mfa_front   - input register, kind decode, unused kinds dropped here
//   mfa_queue   - short item queue so the input side keeps moving while the back is busy
//   mfa_back    - accumulator registers, one shared multiplier, normalize sequencer,
//                 output register that holds a result until it is taken
//   mfa_divider - signed truncating divider shared by gcd, reduction and fold
//
// only normalize produces a result item; a zero denominator gives an all-zero
// result with zero_denominator set and leaves the accumulator untouched
module mixed_fraction_accumulator_unit #(
    parameter int QUEUE_DEPTH = mfa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mfa_pkg::KIND_W-1:0]         kind,
    input  logic signed [mfa_pkg::DATA_W-1:0]  operand_whole,
    input  logic signed [mfa_pkg::DATA_W-1:0]  operand_numerator,
    input  logic signed [mfa_pkg::DATA_W-1:0]  operand_denominator,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mfa_pkg::DATA_W-1:0]  result_whole,
    output logic signed [mfa_pkg::DATA_W-1:0]  result_numerator,
    output logic signed [mfa_pkg::DATA_W-1:0]  result_denominator,
    output logic                               zero_denominator
);
    import mfa_pkg::*;

    // front to queue
    logic     push;
    item_t    push_item;
    logic     q_full;

    // queue to back
    logic     head_valid;
    item_t    head_item;
    logic     pop;

    // back to divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    mfa_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .kind                (kind),
        .operand_whole       (operand_whole),
        .operand_numerator   (operand_numerator),
        .operand_denominator (operand_denominator),
        .push                (push),
        .push_item           (push_item),
        .q_full              (q_full)
    );

    mfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    mfa_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // accumulator and sequencer; output register lives here
    mfa_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head_valid         (head_valid),
        .head_item          (head_item),
        .pop                (pop),
        .div_req            (div_req),
        .div_rsp            (div_rsp),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .result_whole       (result_whole),
        .result_numerator   (result_numerator),
        .result_denominator (result_denominator),
        .zero_denominator   (zero_denominator)
    );

endmodule
